>>> src/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// shared types, character codes and float constants of the text parser
// ----------------------------------------------------------------------------
package dtf_pkg;

  // character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // single precision constants
  localparam logic [31:0] F_CENTI = 32'h3C23D70A;
  localparam logic [31:0] F_DECI  = 32'h3DCCCCCD;
  localparam logic [31:0] F_TEN   = 32'h41200000;
  localparam logic [31:0] F_INF   = 32'h7F800000;

  // biased exponent of bit 31 of the conversion word
  localparam logic [7:0] CONV_EXP = 8'd158;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ROUND,
    S_SCALE,
    S_MULR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_conv;
    logic norm_shift;
    logic conv_round;
    logic mul_load;
    logic mul_round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic term;
    logic term_zero;
    logic normed;
    logic scale_done;
    logic out_busy;
  } status_t;

  // round to nearest even: returns carry out and rounded significand
  function automatic logic [24:0] rne24(input logic [23:0] m, input logic g,
                                        input logic st);
    logic up;
    up = g & (st | m[0]);
    return {1'b0, m} + {24'd0, up};
  endfunction

endpackage

>>> src/dtf_if.sv
// ----------------------------------------------------------------------------
// dtf_if
// valid/ready channels for characters in and parse results out
// ----------------------------------------------------------------------------
interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       start_req;
  logic [7:0] position;

  modport source (output valid, output character, output start_req, output position,
                  input ready);
  modport sink (input valid, input character, input start_req, input position,
                output ready);
endinterface

interface dtf_out_if;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [31:0]       value_bits;
  logic [7:0]        next_position;
  logic [26:0]       mantissa;
  logic signed [7:0] decimal_exponent;
  logic              negative;

  modport source (output valid, output valid_res, output value_bits, output next_position,
                  output mantissa, output decimal_exponent, output negative,
                  input ready);
  modport sink (input valid, input valid_res, input value_bits, input next_position,
                input mantissa, input decimal_exponent, input negative,
                output ready);
endinterface

>>> src/decimal_text_to_float_parser.sv
// Conversion: a terminator starts conversion: up to 31 normalize shifts, one
// round, then a scale multiply and a product round per step (one step per power
// of ten, up to 127, or per hundred on the fraction side), and the load of the
// result beat, held while the output is stalled.
// Throughput: one character per cycle while parsing; no input during conversion.
// Reset (rst, synchronous) returns to idle with no number in progress.
// ----------------------------------------------------------------------------
// decimal_text_to_float_parser
// parses decimal text into mantissa, exponent and single precision value
// ----------------------------------------------------------------------------
module decimal_text_to_float_parser #(
  parameter int MAX_DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  dtf_in_if.sink    in_ch,
  dtf_out_if.source out_ch
);
  import dtf_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    accepting;

  assign in_ch.ready = accepting;

  dtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .accepting (accepting)
  );

  dtf_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_ch.valid && accepting),
    .character        (in_ch.character),
    .start_req        (in_ch.start_req),
    .position         (in_ch.position),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .valid_res        (out_ch.valid_res),
    .value_bits       (out_ch.value_bits),
    .next_position    (out_ch.next_position),
    .mantissa         (out_ch.mantissa),
    .decimal_exponent (out_ch.decimal_exponent),
    .negative         (out_ch.negative)
  );

endmodule

>>> src/dtf_ctrl.sv
// ----------------------------------------------------------------------------
// dtf_ctrl
// sequencer: parse, normalize, round, scale loop, result hand-off
// ----------------------------------------------------------------------------
module dtf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  dtf_pkg::status_t status,
  output dtf_pkg::cmd_t    cmd,
  output logic             accepting
);
  import dtf_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    accepting = 1'b0;
    case (state)
      S_IDLE: begin
        accepting = 1'b1;
        if (status.term) begin
          cmd.load_conv = 1'b1;
          state_next = status.term_zero ? S_DONE : S_NORM;
        end
      end
      S_NORM: begin
        if (status.normed) begin
          state_next = S_ROUND;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.conv_round = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (status.scale_done) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_load = 1'b1;
          state_next = S_MULR;
        end
      end
      S_MULR: begin
        cmd.mul_round = 1'b1;
        state_next = S_SCALE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/dtf_datapath.sv
// ----------------------------------------------------------------------------
// dtf_datapath
// number state, int-to-float conversion, float multiplier, output register
// ----------------------------------------------------------------------------
module dtf_datapath #(
  parameter int MAX_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         character,
  input  logic               start_req,
  input  logic [7:0]         position,
  input  dtf_pkg::cmd_t      cmd,
  output dtf_pkg::status_t   status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               valid_res,
  output logic [31:0]        value_bits,
  output logic [7:0]         next_position,
  output logic [26:0]        mantissa,
  output logic signed [7:0]  decimal_exponent,
  output logic               negative
);
  import dtf_pkg::*;

  localparam int ACC_W = $clog2(10 ** MAX_DIGITS);

  // number state
  logic              parsing, parsing_next;
  logic              neg, neg_next;
  logic              ap, ap_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic signed [7:0] ecnt, ecnt_next;
  logic [3:0]        ds, ds_next;
  logic [7:0]        cpos, cpos_next;
  logic              term_c;

  // float working registers
  logic [31:0]       w;
  logic [7:0]        fexp;
  logic [31:0]       f;
  logic signed [7:0] sc;
  logic [47:0]       prod;
  logic signed [9:0] pexp;
  logic              pinf;

  logic              is_digit;
  logic [3:0]        dval;
  logic              run;

  // one character step
  always_comb begin
    parsing_next = parsing;
    neg_next = neg;
    ap_next = ap;
    acc_next = acc;
    ecnt_next = ecnt;
    ds_next = ds;
    cpos_next = cpos;
    term_c = 1'b0;
    run = 1'b0;
    is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
    dval = 4'(character - CH_ZERO);
    if (start_req) begin
      neg_next = 1'b0;
      ap_next = 1'b0;
      acc_next = '0;
      ecnt_next = '0;
      ds_next = '0;
      parsing_next = 1'b1;
      cpos_next = position;
      if (character == CH_MINUS || character == CH_PLUS) begin
        neg_next = (character == CH_MINUS);
        cpos_next = position + 8'd1;
      end else begin
        run = 1'b1;
      end
    end else begin
      run = parsing;
    end
    if (run) begin
      if (is_digit) begin
        if (ds_next < 4'(MAX_DIGITS + 1)) begin
          ds_next = ds_next + 4'd1;
        end
        if (ds_next <= 4'(MAX_DIGITS)) begin
          if (ap_next) begin
            ecnt_next = ecnt_next - 8'sd1;
          end
          acc_next = ACC_W'(acc_next * ACC_W'(10)) + ACC_W'(dval);
        end else if (!ap_next && ecnt_next < 8'sd127) begin
          ecnt_next = ecnt_next + 8'sd1;
        end
        cpos_next = cpos_next + 8'd1;
      end else if (character == CH_POINT && !ap_next) begin
        ap_next = 1'b1;
        cpos_next = cpos_next + 8'd1;
      end else begin
        parsing_next = 1'b0;
        term_c = 1'b1;
      end
    end
  end

  // number state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parsing <= 1'b0;
      neg <= 1'b0;
      ap <= 1'b0;
      acc <= '0;
      ecnt <= '0;
      ds <= '0;
      cpos <= '0;
    end else if (in_fire) begin
      parsing <= parsing_next;
      neg <= neg_next;
      ap <= ap_next;
      acc <= acc_next;
      ecnt <= ecnt_next;
      ds <= ds_next;
      cpos <= cpos_next;
    end
  end

  // scale step selection
  logic [31:0]       kconst;
  logic signed [7:0] sc_step;
  always_comb begin
    if (sc <= -8'sd2) begin
      kconst = F_CENTI;
      sc_step = sc + 8'sd2;
    end else if (sc < 8'sd0) begin
      kconst = F_DECI;
      sc_step = '0;
    end else begin
      kconst = F_TEN;
      sc_step = sc - 8'sd1;
    end
  end

  // rounding of the conversion word and of the product
  logic [24:0]       conv_r;
  logic [23:0]       pm;
  logic              pg, pst;
  logic [24:0]       mul_r;
  logic signed [9:0] mexp;
  always_comb begin
    conv_r = rne24(w[31:8], w[7], |w[6:0]);
    if (prod[47]) begin
      pm = prod[47:24];
      pg = prod[23];
      pst = |prod[22:0];
    end else begin
      pm = prod[46:23];
      pg = prod[22];
      pst = |prod[21:0];
    end
    mul_r = rne24(pm, pg, pst);
    mexp = pexp + 10'(prod[47]) + 10'(mul_r[24]);
  end

  // float unit registers
  always_ff @(posedge clk) begin
    if (cmd.load_conv) begin
      w <= 32'(acc_next);
      fexp <= CONV_EXP;
      f <= '0;
      sc <= ecnt_next;
    end
    if (cmd.norm_shift) begin
      w <= {w[30:0], 1'b0};
      fexp <= fexp - 8'd1;
    end
    if (cmd.conv_round) begin
      f <= {1'b0, fexp + 8'(conv_r[24]), conv_r[24] ? 23'd0 : conv_r[22:0]};
    end
    if (cmd.mul_load) begin
      prod <= {1'b1, f[22:0]} * {1'b1, kconst[22:0]};
      pexp <= $signed({2'b00, f[30:23]}) + $signed({2'b00, kconst[30:23]}) - 10'sd127;
      pinf <= (f[30:23] == 8'hFF);
      sc <= sc_step;
    end
    if (cmd.mul_round) begin
      if (pinf || mexp >= 10'sd255) begin
        f <= F_INF;
      end else begin
        f <= {1'b0, mexp[7:0], mul_r[24] ? 23'd0 : mul_r[22:0]};
      end
    end
  end

  // output register
  logic vr;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign vr = (ds != 4'd0);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      valid_res <= vr;
      value_bits <= vr ? {neg, f[30:0]} : 32'd0;
      next_position <= cpos;
      mantissa <= vr ? 27'(32'(acc)) : 27'd0;
      decimal_exponent <= vr ? ecnt : 8'sd0;
      negative <= neg;
    end
  end

  // status to the sequencer
  assign status.term = in_fire && term_c;
  assign status.term_zero = (acc_next == '0);
  assign status.normed = w[31];
  assign status.scale_done = (sc == 8'sd0);
  assign status.out_busy = out_valid && !out_ready;

endmodule

>>> src/dtf_checker.sv
// ----------------------------------------------------------------------------
// dtf_checker
// port-level checks of the result channel of the text parser
// ----------------------------------------------------------------------------
module dtf_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              valid_res,
  input logic [31:0]       value_bits,
  input logic [26:0]       mantissa,
  input logic signed [7:0] decimal_exponent,
  input logic              negative
);

  // stalled beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(value_bits) && $stable(mantissa))
    else $error("result beat changed while stalled");

  // no digits gives zero fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> value_bits == 32'd0 && mantissa == 27'd0
      && decimal_exponent == 8'sd0)
    else $error("empty number with nonzero fields");

  // zero mantissa is an unscaled signed zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res && mantissa == 27'd0 |-> value_bits[30:0] == 31'd0)
    else $error("zero mantissa scaled");

  // sign bit follows the sign seen
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> value_bits[31] == negative)
    else $error("sign bit mismatch");

endmodule

bind decimal_text_to_float_parser dtf_checker u_dtf_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .valid_res        (out_ch.valid_res),
  .value_bits       (out_ch.value_bits),
  .mantissa         (out_ch.mantissa),
  .decimal_exponent (out_ch.decimal_exponent),
  .negative         (out_ch.negative)
);
